[rtl/core/lcw_pkg.sv]
// Shared types and constants for the lattice cell wrap table core.
// Used by lcw_ctrl, lcw_datapath and lattice_cell_wrap_table_core; no dependencies.
package lcw_pkg;

  // Command codes of an input beat (code 3 behaves as wrap only)
  localparam logic [1:0] CMD_WRAP   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam int KINDS    = 4;
  localparam int REGS     = 3;
  localparam int SUB_W    = 5;
  localparam int STEP_W   = 5;
  localparam int ADJ_STEPS = 18;

  localparam logic [1:0] CFG_LAST = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_SINGULAR  = 2'd3
  } lcw_status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE, S_ADJ, S_DET, S_SIGN, S_MAC, S_DLOAD, S_DIV, S_STORE,
    S_TSTART, S_TRUN, S_DONE
  } lcw_state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ADJ, OP_DET, OP_SIGN, OP_MAC, OP_DLOAD, OP_DSTEP,
    OP_STORE, OP_TSTART, OP_TRUN, OP_PUBLISH
  } lcw_op_t;

  typedef struct packed {
    lcw_op_t           op;
    logic [STEP_W-1:0] step;
    logic [1:0]        lane;
    logic              phase;  // 0: reduce by adjugate, 1: map back by lattice
  } lcw_ctrl_t;

  typedef struct packed {
    logic singular;
    logic div_done;
    logic tbl_done;
  } lcw_stat_t;

  // Matrix entry operands for the adjugate cofactor products, two per entry,
  // entries in row-major order; matrix entry index is row*3+column.
  localparam logic [3:0] ADJ_OP_A [ADJ_STEPS] = '{
    4'd4, 4'd5, 4'd7, 4'd8, 4'd1, 4'd2,
    4'd5, 4'd3, 4'd8, 4'd6, 4'd2, 4'd0,
    4'd3, 4'd4, 4'd6, 4'd7, 4'd0, 4'd1
  };
  localparam logic [3:0] ADJ_OP_B [ADJ_STEPS] = '{
    4'd8, 4'd7, 4'd2, 4'd1, 4'd5, 4'd4,
    4'd6, 4'd8, 4'd0, 4'd2, 4'd3, 4'd5,
    4'd7, 4'd6, 4'd1, 4'd0, 4'd4, 4'd3
  };

endpackage

[rtl/core/lcw_ctrl.sv]
// Sequencer for the lattice cell wrap table core.
// Depends on lcw_pkg; drives lcw_datapath through lcw_ctrl_t commands.
module lcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lcw_pkg::lcw_stat_t  stat,
  output lcw_pkg::lcw_ctrl_t  ctrl
);

  lcw_pkg::lcw_state_t        state_r, state_nxt;
  logic [lcw_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [1:0]                 lane_r, lane_nxt;
  logic                       phase_r, phase_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       publish_ok;

  assign publish_ok = !out_valid_r || !out_stall;

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    lane_nxt  = lane_r;
    phase_nxt = phase_r;
    unique case (state_r)
      lcw_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = lcw_pkg::S_ADJ;
          step_nxt  = '0;
        end
      end
      lcw_pkg::S_ADJ: begin
        if (step_r == lcw_pkg::STEP_W'(lcw_pkg::ADJ_STEPS - 1)) begin
          state_nxt = lcw_pkg::S_DET;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      lcw_pkg::S_DET: begin
        if (step_r == lcw_pkg::STEP_W'(2)) begin
          state_nxt = lcw_pkg::S_SIGN;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      lcw_pkg::S_SIGN: begin
        if (stat.singular) begin
          state_nxt = lcw_pkg::S_DONE;
        end else begin
          state_nxt = lcw_pkg::S_MAC;
          lane_nxt  = '0;
          phase_nxt = 1'b0;
          step_nxt  = '0;
        end
      end
      lcw_pkg::S_MAC: begin
        if (step_r == lcw_pkg::STEP_W'(2)) begin
          state_nxt = lcw_pkg::S_DLOAD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      lcw_pkg::S_DLOAD: state_nxt = lcw_pkg::S_DIV;
      lcw_pkg::S_DIV: begin
        if (stat.div_done) state_nxt = lcw_pkg::S_STORE;
      end
      lcw_pkg::S_STORE: begin
        step_nxt = '0;
        if (lane_r == 2'd2) begin
          if (phase_r) begin
            state_nxt = lcw_pkg::S_TSTART;
          end else begin
            state_nxt = lcw_pkg::S_MAC;
            phase_nxt = 1'b1;
            lane_nxt  = '0;
          end
        end else begin
          state_nxt = lcw_pkg::S_MAC;
          lane_nxt  = lane_r + 1'b1;
        end
      end
      lcw_pkg::S_TSTART: state_nxt = lcw_pkg::S_TRUN;
      lcw_pkg::S_TRUN: begin
        if (stat.tbl_done) state_nxt = lcw_pkg::S_DONE;
      end
      lcw_pkg::S_DONE: begin
        if (publish_ok) state_nxt = lcw_pkg::S_IDLE;
      end
      default: state_nxt = lcw_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    ctrl.op    = lcw_pkg::OP_NONE;
    ctrl.step  = step_r;
    ctrl.lane  = lane_r;
    ctrl.phase = phase_r;
    unique case (state_r)
      lcw_pkg::S_IDLE:   ctrl.op = in_valid ? lcw_pkg::OP_LOAD : lcw_pkg::OP_NONE;
      lcw_pkg::S_ADJ:    ctrl.op = lcw_pkg::OP_ADJ;
      lcw_pkg::S_DET:    ctrl.op = lcw_pkg::OP_DET;
      lcw_pkg::S_SIGN:   ctrl.op = lcw_pkg::OP_SIGN;
      lcw_pkg::S_MAC:    ctrl.op = lcw_pkg::OP_MAC;
      lcw_pkg::S_DLOAD:  ctrl.op = lcw_pkg::OP_DLOAD;
      lcw_pkg::S_DIV:    ctrl.op = lcw_pkg::OP_DSTEP;
      lcw_pkg::S_STORE:  ctrl.op = lcw_pkg::OP_STORE;
      lcw_pkg::S_TSTART: ctrl.op = lcw_pkg::OP_TSTART;
      lcw_pkg::S_TRUN:   ctrl.op = lcw_pkg::OP_TRUN;
      lcw_pkg::S_DONE:   ctrl.op = publish_ok ? lcw_pkg::OP_PUBLISH : lcw_pkg::OP_NONE;
      default:           ctrl.op = lcw_pkg::OP_NONE;
    endcase
  end

  // Output beat valid: set on publish, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (state_r == lcw_pkg::S_DONE && publish_ok) out_valid_nxt = 1'b1;
  end

  assign in_stall  = (state_r != lcw_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcw_pkg::S_IDLE;
      step_r      <= '0;
      lane_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      lane_r      <= lane_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/lcw_datapath.sv]
// Datapath of the lattice cell wrap table core: lattice registers, shared
// multiplier, serial divider and cell table memory. Depends on lcw_pkg.
module lcw_datapath #(
  parameter int ENTRIES_PER_KIND = 32,
  parameter int COORD_BITS       = 16,
  parameter int MATRIX_BITS      = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcw_pkg::lcw_ctrl_t            ctrl,
  output lcw_pkg::lcw_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [3*MATRIX_BITS-1:0]      cfg_wdata,
  input  logic [1:0]                    in_cmd,
  input  logic [1:0]                    in_cell_kind,
  input  logic signed [COORD_BITS-1:0]  in_pos_x,
  input  logic signed [COORD_BITS-1:0]  in_pos_y,
  input  logic signed [COORD_BITS-1:0]  in_pos_z,
  output logic signed [COORD_BITS-1:0]  out_wrapped_x,
  output logic signed [COORD_BITS-1:0]  out_wrapped_y,
  output logic signed [COORD_BITS-1:0]  out_wrapped_z,
  output logic [lcw_pkg::SUB_W-1:0]     out_sub_index,
  output logic [1:0]                    out_status
);

  localparam int RW   = 3 * MATRIX_BITS;
  localparam int ADJW = 2 * MATRIX_BITS + 1;
  localparam int DW   = 3 * MATRIX_BITS + 2;
  localparam int MBW  = (COORD_BITS > DW + 1) ? COORD_BITS : DW + 1;
  localparam int PW   = ADJW + MBW;
  localparam int AW   = PW + 2;
  localparam int DCW  = $clog2(AW + 1);
  localparam int CW   = $clog2(ENTRIES_PER_KIND + 1);
  localparam int TD   = lcw_pkg::KINDS * ENTRIES_PER_KIND;
  localparam int TAW  = $clog2(TD);
  localparam int EW   = 3 * COORD_BITS;

  // Configuration and captured beat
  logic [RW-1:0]                 row_r [lcw_pkg::REGS];
  logic [1:0]                    cmd_r, kind_r;
  logic signed [COORD_BITS-1:0]  pos_r [3];

  // Derived lattice quantities and working values
  logic signed [ADJW-1:0]        adj_r [9];
  logic [DW-1:0]                 det_r;
  logic                          neg_r;
  logic signed [AW-1:0]          acc_r;
  logic [AW-1:0]                 dq_r;
  logic [DW-1:0]                 rem_r;
  logic                          dsign_r;
  logic [DCW-1:0]                dcnt_r;
  logic [DW-1:0]                 x_r [3];
  logic [COORD_BITS-1:0]         w_r [3];

  // Table state
  logic [CW-1:0]                 cnt_r [lcw_pkg::KINDS];
  logic [CW-1:0]                 k_r, kq_r;
  logic                          pend_r, tbl_done_r;
  logic [lcw_pkg::SUB_W-1:0]     sub_r;
  lcw_pkg::lcw_status_t          stat_r;
  logic [EW-1:0]                 mem [TD];
  logic [EW-1:0]                 mem_rd_r;

  // Combinational signals
  logic signed [MATRIX_BITS-1:0] lat [9];
  logic signed [ADJW-1:0]        ma;
  logic signed [MBW-1:0]         mb;
  logic signed [PW-1:0]          prod;
  logic signed [AW-1:0]          acc_sum;
  logic [3:0]                    lane_idx, det_idx;
  logic [1:0]                    sj;
  logic [DW:0]                   div_sh;
  logic                          div_ge;
  logic [DW-1:0]                 rem_nxt;
  logic [AW-1:0]                 q_signed;
  logic [TAW-1:0]                base, mem_addr;
  logic [CW-1:0]                 n;
  logic [EW-1:0]                 wv;
  logic                          match, mem_we, mem_re;

  // Unpack matrix entries
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign lat[r*3+c] = row_r[r][c*MATRIX_BITS +: MATRIX_BITS];
    end
  end

  assign sj       = ctrl.step[1:0];
  assign lane_idx = 4'({ctrl.lane, 1'b0}) + 4'(ctrl.lane) + 4'(sj);
  assign det_idx  = 4'({sj, 1'b0}) + 4'(sj);

  // Select multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (ctrl.op)
      lcw_pkg::OP_ADJ: begin
        ma = ADJW'(lat[lcw_pkg::ADJ_OP_A[ctrl.step]]);
        mb = MBW'(lat[lcw_pkg::ADJ_OP_B[ctrl.step]]);
      end
      lcw_pkg::OP_DET: begin
        ma = adj_r[det_idx];
        mb = MBW'(lat[4'(sj)]);
      end
      lcw_pkg::OP_MAC: begin
        if (ctrl.phase) begin
          ma = ADJW'(lat[lane_idx]);
          mb = MBW'($signed({1'b0, x_r[sj]}));
        end else begin
          ma = adj_r[lane_idx];
          mb = MBW'(pos_r[sj]);
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod    = PW'(ma) * PW'(mb);
  assign acc_sum = (sj == 2'd0) ? AW'(prod) : acc_r + AW'(prod);

  // Restoring divider step: one quotient bit a cycle
  assign div_sh   = {rem_r, dq_r[AW-1]};
  assign div_ge   = (div_sh >= {1'b0, det_r});
  assign rem_nxt  = div_ge ? DW'(div_sh - {1'b0, det_r}) : DW'(div_sh);
  assign q_signed = (dsign_r ^ neg_r) ? -dq_r : dq_r;

  // Table addressing and compare
  assign base  = TAW'(TAW'(kind_r) * TAW'(ENTRIES_PER_KIND));
  assign n     = cnt_r[kind_r];
  assign wv    = {w_r[2], w_r[1], w_r[0]};
  assign match = pend_r && (mem_rd_r == wv);

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = base + TAW'(k_r);
    if (ctrl.op == lcw_pkg::OP_TSTART && cmd_r == lcw_pkg::CMD_ADD &&
        n != CW'(ENTRIES_PER_KIND)) begin
      mem_we   = 1'b1;
      mem_addr = base + TAW'(n);
    end
    if (ctrl.op == lcw_pkg::OP_TRUN && !tbl_done_r && !match && k_r < n) begin
      mem_re = 1'b1;
    end
  end

  // Cell table memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= wv;
    if (mem_re) mem_rd_r <= mem[mem_addr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]   <= RW'(1);
      row_r[1]   <= RW'(1) << MATRIX_BITS;
      row_r[2]   <= RW'(1) << (2 * MATRIX_BITS);
      for (int i = 0; i < lcw_pkg::KINDS; i++) cnt_r[i] <= '0;
      tbl_done_r <= 1'b0;
      pend_r     <= 1'b0;
      dcnt_r     <= '0;
      det_r      <= DW'(1);
      k_r        <= '0;
    end else begin
      if (cfg_we && cfg_idx <= lcw_pkg::CFG_LAST) row_r[cfg_idx] <= cfg_wdata;
      unique case (ctrl.op)
        lcw_pkg::OP_LOAD: begin
          cmd_r      <= in_cmd;
          kind_r     <= in_cell_kind;
          pos_r[0]   <= in_pos_x;
          pos_r[1]   <= in_pos_y;
          pos_r[2]   <= in_pos_z;
          tbl_done_r <= 1'b0;
        end
        lcw_pkg::OP_ADJ: begin
          if (!ctrl.step[0]) acc_r <= AW'(prod);
          else adj_r[ctrl.step[4:1]] <= ADJW'(acc_r - AW'(prod));
        end
        lcw_pkg::OP_DET: begin
          acc_r <= acc_sum;
          if (sj == 2'd2) det_r <= DW'(acc_sum);
        end
        lcw_pkg::OP_SIGN: begin
          neg_r <= det_r[DW-1];
          if (det_r[DW-1]) det_r <= -det_r;
        end
        lcw_pkg::OP_MAC: acc_r <= acc_sum;
        lcw_pkg::OP_DLOAD: begin
          dsign_r <= acc_r[AW-1];
          dq_r    <= acc_r[AW-1] ? -acc_r : acc_r;
          rem_r   <= '0;
          dcnt_r  <= DCW'(AW);
        end
        lcw_pkg::OP_DSTEP: begin
          if (dcnt_r != '0) begin
            rem_r  <= rem_nxt;
            dq_r   <= {dq_r[AW-2:0], div_ge};
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        lcw_pkg::OP_STORE: begin
          if (ctrl.phase) w_r[ctrl.lane] <= q_signed[COORD_BITS-1:0];
          else x_r[ctrl.lane] <= (dsign_r && rem_r != '0) ? det_r - rem_r : rem_r;
        end
        lcw_pkg::OP_TSTART: begin
          k_r        <= '0;
          pend_r     <= 1'b0;
          sub_r      <= '0;
          stat_r     <= lcw_pkg::STAT_OK;
          tbl_done_r <= (cmd_r != lcw_pkg::CMD_LOOKUP);
          if (cmd_r == lcw_pkg::CMD_ADD) begin
            if (n == CW'(ENTRIES_PER_KIND)) begin
              stat_r <= lcw_pkg::STAT_FULL;
            end else begin
              cnt_r[kind_r] <= n + 1'b1;
              sub_r         <= lcw_pkg::SUB_W'(n);
            end
          end
        end
        lcw_pkg::OP_TRUN: begin
          // Issue one read a cycle, compare the previous read
          if (!tbl_done_r) begin
            priority if (match) begin
              sub_r      <= lcw_pkg::SUB_W'(kq_r);
              tbl_done_r <= 1'b1;
              pend_r     <= 1'b0;
            end else if (k_r < n) begin
              kq_r   <= k_r;
              k_r    <= k_r + 1'b1;
              pend_r <= 1'b1;
            end else begin
              stat_r     <= lcw_pkg::STAT_NOT_FOUND;
              tbl_done_r <= 1'b1;
              pend_r     <= 1'b0;
            end
          end
        end
        lcw_pkg::OP_PUBLISH: begin
          if (det_r == '0) begin
            out_wrapped_x <= '0;
            out_wrapped_y <= '0;
            out_wrapped_z <= '0;
            out_sub_index <= '0;
            out_status    <= lcw_pkg::STAT_SINGULAR;
          end else begin
            out_wrapped_x <= w_r[0];
            out_wrapped_y <= w_r[1];
            out_wrapped_z <= w_r[2];
            out_sub_index <= sub_r;
            out_status    <= stat_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.singular = (det_r == '0);
  assign stat.div_done = (dcnt_r == '0);
  assign stat.tbl_done = tbl_done_r;

endmodule

[rtl/core/lattice_cell_wrap_table_core.sv]
// Top level of the lattice cell wrap table core.
// Depends on lcw_pkg, lcw_ctrl and lcw_datapath.
//
// Reduces a signed 3D position into the unit cell of the lattice held in
// three row registers, then optionally adds the wrapped position to one of
// four cell tables or looks it up there.
// Input channel: in_valid/in_stall with cmd, cell_kind and pos_x/y/z; a beat
// is taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with wrapped_x/y/z, sub_index, status;
// one result beat per input beat, held steady while out_stall is high.
// Sequence: accept, cofactor, determinant and sign steps, then six multiply
// and divide passes, each a multiply-accumulate, a divider load, a serial
// divide over AW = 5*MATRIX_BITS + 6 quotient bits and a store, then the wrap
// or add step, or a lookup over up to ENTRIES_PER_KIND entries, and publish.
// A singular lattice goes from the sign step straight to publish. The serial
// divider takes most of the time; one item is in flight at a time and the
// next beat is taken once the result has moved into the output register.
// Reset (rst_n low, synchronous): identity lattice, all tables empty.
// Configuration writes go straight to the row registers; write only when idle.
module lattice_cell_wrap_table_core #(
  parameter int ENTRIES_PER_KIND = 32,
  parameter int COORD_BITS       = 16,
  parameter int MATRIX_BITS      = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [3*MATRIX_BITS-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [1:0]                    in_cell_kind,
  input  logic signed [COORD_BITS-1:0]  in_pos_x,
  input  logic signed [COORD_BITS-1:0]  in_pos_y,
  input  logic signed [COORD_BITS-1:0]  in_pos_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_wrapped_x,
  output logic signed [COORD_BITS-1:0]  out_wrapped_y,
  output logic signed [COORD_BITS-1:0]  out_wrapped_z,
  output logic [lcw_pkg::SUB_W-1:0]     out_sub_index,
  output logic [1:0]                    out_status
);

  lcw_pkg::lcw_ctrl_t ctrl;
  lcw_pkg::lcw_stat_t stat;

  lcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lcw_datapath #(
    .ENTRIES_PER_KIND (ENTRIES_PER_KIND),
    .COORD_BITS       (COORD_BITS),
    .MATRIX_BITS      (MATRIX_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_cmd        (in_cmd),
    .in_cell_kind  (in_cell_kind),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .out_wrapped_x (out_wrapped_x),
    .out_wrapped_y (out_wrapped_y),
    .out_wrapped_z (out_wrapped_z),
    .out_sub_index (out_sub_index),
    .out_status    (out_status)
  );

endmodule
